/* src/masked_signal_queue_macros.svh */
`ifndef MASKED_SIGNAL_QUEUE_MACROS_SVH
`define MASKED_SIGNAL_QUEUE_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define MSQ_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("msq check failed");

// next-cycle implication
`define MSQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("msq check failed");

`endif

/* src/msq_pkg.sv */
package msq_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CK,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_ACT_RD,
      ST_ACT_CK,
      ST_DONE
   } state_type;

   localparam logic [2:0] CMD_POST    = 3'd0;
   localparam logic [2:0] CMD_DELIVER = 3'd1;
   localparam logic [2:0] CMD_ACTION  = 3'd2;
   localparam logic [2:0] CMD_MASK    = 3'd3;
   localparam logic [2:0] CMD_WAIT    = 3'd4;

   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_INVALID = 2'd1;
   localparam logic [1:0] STS_FULL    = 2'd2;
   localparam logic [1:0] STS_NONE    = 2'd3;

   localparam logic [1:0] VRD_NONE    = 2'd0;
   localparam logic [1:0] VRD_IGNORE  = 2'd1;
   localparam logic [1:0] VRD_DESTROY = 2'd2;
   localparam logic [1:0] VRD_RUN     = 2'd3;

   localparam logic [1:0] ACT_IGNORE  = 2'd1;
   localparam logic [1:0] ACT_HANDLER = 2'd2;

   localparam int SIG_W       = 5;
   localparam int SIG_SLOTS   = 32;
   localparam int VALUE_W     = 64;
   localparam int MASK_W      = 32;
   localparam logic [63:0] ALIGN_MASK = 64'hF;
   localparam logic [63:0] RET_SLOT   = 64'd8;

   typedef struct packed {
      logic [1:0]  status;
      logic        woke;
      logic [4:0]  signal;
      logic [63:0] value;
      logic [1:0]  verdict;
      logic [31:0] saved;
      logic [63:0] frame;
      logic [63:0] hstack;
   } res_type;

endpackage

/* src/msq_ram.sv */
module msq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* src/masked_signal_queue.sv */
// Pending-signal queue with blocking mask and per-signal actions. One transaction
// at a time: post, set action, set mask and begin wait go from idle straight to
// the done state; a deliver that scans reads and checks each entry scanned,
// reads and writes each entry shifted down to close the gap, one entry at a
// time through the single read port of the queue RAM, then checks the action.
// A result waits in the output register while the next transaction is accepted.
`include "masked_signal_queue_macros.svh"

module masked_signal_queue #(
   parameter int QUEUE_DEPTH  = 32,
   parameter int SIGNAL_COUNT = 32,
   parameter int KILL_SIGNAL  = 9,
   parameter int FRAME_BYTES  = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic        csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [4:0]  req_signal_number,
   input  logic [63:0] req_signal_value,
   input  logic [1:0]  req_action_kind,
   input  logic [31:0] req_mask_word,
   input  logic        req_from_user_mode,
   input  logic [63:0] req_stack_pointer,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_woke_waiter,
   output logic [4:0]  rsp_out_signal,
   output logic [63:0] rsp_out_value,
   output logic [1:0]  rsp_verdict,
   output logic [31:0] rsp_saved_mask,
   output logic [63:0] rsp_frame_address,
   output logic [63:0] rsp_handler_stack
);
   import msq_pkg::*;

   localparam int QA = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LW = $clog2(QUEUE_DEPTH + 1);
   localparam int QW = SIG_W + VALUE_W;
   localparam int AW = 2 + MASK_W;
   localparam logic [4:0]  KILL = 5'(KILL_SIGNAL);
   localparam logic [63:0] FB   = 64'(FRAME_BYTES);

   state_type         state_ff, state_in;
   logic [LW-1:0]     len_ff, len_in;
   logic [QA-1:0]     idx_ff, idx_in;
   logic [31:0]       bmask_ff, bmask_in;
   logic              waiting_ff, waiting_in;
   logic [31:0]       wset_ff, wset_in;
   logic [31:0]       wold_ff, wold_in;
   logic [31:0]       avalid_ff, avalid_in;
   logic              hep_ff;
   logic [4:0]        sig_ff, sig_in;
   logic [63:0]       sp_ff, sp_in;
   res_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   res_type           out_ff, out_in;

   logic              accept, sig_ok, rsp_free, match, more_scan, more_shift, go_scan;
   logic [LW-1:0]     idx_next;
   logic [4:0]        q_sig;
   logic [31:0]       sig_bit;
   logic [1:0]        kind;
   logic [31:0]       amask;
   logic              q_we, a_we;
   logic [QA-1:0]     q_waddr, q_raddr;
   logic [QW-1:0]     q_wdata, q_rdata;
   logic [AW-1:0]     a_rdata;

   msq_ram #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
      .rd_addr(q_raddr), .rd_data(q_rdata)
   );

   msq_ram #(.WIDTH(AW), .DEPTH(SIG_SLOTS)) u_action (
      .clock(clock), .wr_en(a_we), .wr_addr(req_signal_number),
      .wr_data({req_action_kind, req_mask_word}),
      .rd_addr(sig_ff), .rd_data(a_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign sig_ok    = (req_signal_number >= 5'd1) &&
                      (32'(req_signal_number) < 32'(SIGNAL_COUNT));
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign go_scan   = req_from_user_mode && !waiting_ff && (len_ff != '0);

   assign idx_next   = LW'(idx_ff) + LW'(1);
   assign q_sig      = q_rdata[QW-1:VALUE_W];
   assign match      = hep_ff ? ((q_sig == KILL) || !bmask_ff[q_sig]) : (q_sig == KILL);
   assign more_scan  = idx_next < len_ff;
   assign more_shift = LW'(idx_ff) < (len_ff - LW'(1));
   assign sig_bit    = 32'(1) << sig_ff;
   assign kind       = avalid_ff[sig_ff] ? a_rdata[AW-1:MASK_W] : 2'd0;
   assign amask      = avalid_ff[sig_ff] ? a_rdata[MASK_W-1:0] : '0;

   assign q_raddr = (state_ff == ST_SHIFT_RD) ? QA'(idx_next) : idx_ff;
   assign a_we    = accept && (req_cmd == CMD_ACTION) && sig_ok;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_DELIVER && go_scan) begin
                  state_in = ST_SCAN_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN_RD:  state_in = ST_SCAN_CK;
         ST_SCAN_CK: begin
            if (match) begin
               state_in = more_shift ? ST_SHIFT_RD : ST_ACT_RD;
            end else begin
               state_in = more_scan ? ST_SCAN_RD : ST_DONE;
            end
         end
         ST_SHIFT_RD: state_in = ST_SHIFT_WR;
         // len_ff already holds the shortened length here
         ST_SHIFT_WR: state_in = (idx_next < len_ff) ? ST_SHIFT_RD : ST_ACT_RD;
         ST_ACT_RD:   state_in = ST_ACT_CK;
         ST_ACT_CK:   state_in = ST_DONE;
         ST_DONE:     state_in = rsp_free ? ST_IDLE : ST_DONE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      len_in       = len_ff;
      idx_in       = idx_ff;
      bmask_in     = bmask_ff;
      waiting_in   = waiting_ff;
      wset_in      = wset_ff;
      wold_in      = wold_ff;
      avalid_in    = avalid_ff;
      sig_in       = sig_ff;
      sp_in        = sp_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      q_we         = 1'b0;
      q_waddr      = QA'(len_ff);
      q_wdata      = {req_signal_number, req_signal_value};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in = '0;
               idx_in = '0;
               sig_in = req_signal_number;
               sp_in  = req_stack_pointer;
               case (req_cmd)
                  CMD_POST: begin
                     if (!sig_ok) begin
                        res_in.status = STS_INVALID;
                     end else if (waiting_ff && wset_ff[req_signal_number]) begin
                        waiting_in    = 1'b0;
                        bmask_in      = wold_ff;
                        res_in.woke   = 1'b1;
                        res_in.signal = req_signal_number;
                     end else if (32'(len_ff) >= 32'(QUEUE_DEPTH)) begin
                        res_in.status = STS_FULL;
                     end else begin
                        q_we   = 1'b1;
                        len_in = len_ff + LW'(1);
                     end
                  end
                  CMD_DELIVER: res_in.status = STS_NONE;
                  CMD_ACTION: begin
                     if (!sig_ok) begin
                        res_in.status = STS_INVALID;
                     end else begin
                        avalid_in[req_signal_number] = 1'b1;
                     end
                  end
                  CMD_MASK: bmask_in = req_mask_word;
                  CMD_WAIT: begin
                     waiting_in = 1'b1;
                     wset_in    = req_mask_word;
                     wold_in    = bmask_ff;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN_CK: begin
            if (match) begin
               sig_in        = q_sig;
               res_in.status = STS_OK;
               res_in.signal = q_sig;
               res_in.value  = q_rdata[VALUE_W-1:0];
               len_in        = len_ff - LW'(1);
            end else begin
               idx_in = QA'(idx_next);
            end
         end
         ST_SHIFT_WR: begin
            q_we    = 1'b1;
            q_waddr = idx_ff;
            q_wdata = q_rdata;
            idx_in  = QA'(idx_next);
         end
         ST_ACT_CK: begin
            if (!hep_ff || sig_ff == KILL) begin
               res_in.verdict = VRD_DESTROY;
            end else if (kind == ACT_IGNORE) begin
               res_in.verdict = VRD_IGNORE;
            end else if (kind != ACT_HANDLER) begin
               res_in.verdict = VRD_DESTROY;
            end else begin
               res_in.verdict = VRD_RUN;
               res_in.saved   = bmask_ff;
               res_in.frame   = (sp_ff - FB) & ~ALIGN_MASK;
               res_in.hstack  = ((sp_ff - FB - (RET_SLOT << 1)) & ~ALIGN_MASK) | RET_SLOT;
               bmask_in       = bmask_ff | amask | sig_bit;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               out_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         bmask_ff     <= '0;
         waiting_ff   <= 1'b0;
         wset_ff      <= '0;
         wold_ff      <= '0;
         avalid_ff    <= '0;
         hep_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         bmask_ff     <= bmask_in;
         waiting_ff   <= waiting_in;
         wset_ff      <= wset_in;
         wold_ff      <= wold_in;
         avalid_ff    <= avalid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            hep_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      sig_ff <= sig_in;
      sp_ff  <= sp_in;
      res_ff <= res_in;
      out_ff <= out_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = out_ff.status;
   assign rsp_woke_waiter   = out_ff.woke;
   assign rsp_out_signal    = out_ff.signal;
   assign rsp_out_value     = out_ff.value;
   assign rsp_verdict       = out_ff.verdict;
   assign rsp_saved_mask    = out_ff.saved;
   assign rsp_frame_address = out_ff.frame;
   assign rsp_handler_stack = out_ff.hstack;

   `MSQ_ASSERT_NOW(a_len_bound, 1'b1, 32'(len_ff) <= 32'(QUEUE_DEPTH))
   `MSQ_ASSERT_NOW(a_scan_in_range, (state_ff == ST_SCAN_RD || state_ff == ST_SCAN_CK), LW'(idx_ff) < len_ff)
   `MSQ_ASSERT_NOW(a_run_is_ok, (state_ff == ST_DONE && res_ff.verdict == VRD_RUN), res_ff.status == STS_OK)
   `MSQ_ASSERT_NEXT(a_busy_after_accept, accept, req_stall)

endmodule
